/* rtl/core/frame_parser_crc32_check_core_assert.svh */
// ----------------------------------------------------------------------------
// frame_parser_crc32_check_core_assert
// Assertion macros shared by the frame parser RTL.
// ----------------------------------------------------------------------------
`ifndef FRAME_PARSER_CRC32_CHECK_CORE_ASSERT_SVH
`define FRAME_PARSER_CRC32_CHECK_CORE_ASSERT_SVH

// Assert that an implication holds on every clock edge outside reset.
`define FPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Assert that the consequent holds in the cycle after the antecedent.
`define FPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/fpc_pkg.sv */
// ----------------------------------------------------------------------------
// fpc_pkg
// Types and constants shared by the frame parser with CRC-32 check.
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [2:0] REG_BIG_ENDIAN  = 3'd0;
  localparam logic [2:0] REG_HEADER_LEN  = 3'd1;
  localparam logic [2:0] REG_LENGTH_LEN  = 3'd2;
  localparam logic [2:0] REG_COMMAND_LEN = 3'd3;
  localparam logic [2:0] REG_CRC_SEED    = 3'd4;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_COMMAND = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAILER = 3'd4
  } phase_t;

  // One result request as it travels from the parser to the output stage.
  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [15:0] command_value;
    logic [16:0] payload_count;
    logic        crc_ok;
    logic        length_error;
  } result_t;

  // One CRC-32 byte update, reflected form.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/fpc_parser.sv */
// ----------------------------------------------------------------------------
// fpc_parser
// Front end: takes one byte a cycle while fire is high, tracks the frame
// phase, runs the CRC and issues result requests into the queue.
// ----------------------------------------------------------------------------
module fpc_parser import fpc_pkg::*; #(
  parameter int MAX_PAYLOAD = 65536
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic [7:0]    in_byte,
  input  logic          big_endian,
  input  logic [2:0]    header_len,
  input  logic [2:0]    length_field_len,
  input  logic [1:0]    command_field_len,
  input  logic [31:0]   crc_seed,
  output logic          res_valid,
  output result_t       res
);

  localparam logic [32:0] MaxPay = 33'(MAX_PAYLOAD);
  localparam int          LeftW  = $clog2(MAX_PAYLOAD + 1);

  phase_t      phase, phase_next;
  logic [2:0]  idx, idx_next;
  logic [31:0] length_accum, length_next;
  logic [15:0] command_accum, command_next;
  logic [31:0] crc_running, crc_next;
  logic [LeftW-1:0] bytes_left, left_next;
  logic [31:0] trailer_accum, trailer_next;

  logic [2:0]  hlen, llen;
  logic [1:0]  clen;
  logic [31:0] crc_base, len_base, len_full;
  logic [32:0] payload;
  logic [31:0] trail_full;

  always_comb begin
    hlen = (header_len > 3'd4) ? 3'd4 : header_len;
    llen = (length_field_len == 3'd0) ? 3'd1 :
           ((length_field_len > 3'd4) ? 3'd4 : length_field_len);
    clen = (command_field_len > 2'd2) ? 2'd2 : command_field_len;
  end

  always_comb begin
    logic        first;
    logic [2:0]  fi;
    phase_t      ph;
    first = (phase == PH_HEADER) && (idx == 3'd0);
    crc_base = first ? (crc_seed ^ ALL_ONES) : crc_running;
    len_base = first ? 32'd0 : length_accum;
    phase_next = phase;
    idx_next = idx;
    length_next = len_base;
    command_next = first ? 16'd0 : command_accum;
    trailer_next = first ? 32'd0 : trailer_accum;
    left_next = first ? '0 : bytes_left;
    crc_next = crc_base;
    res_valid = 1'b0;
    res = '0;
    len_full = '0;
    payload = '0;
    trail_full = '0;
    ph = phase;
    fi = idx;
    // Resolve skipped parts first: empty header, command or payload.
    if (ph == PH_HEADER && fi >= hlen) begin
      ph = PH_LENGTH;
      fi = 3'd0;
    end
    if (ph == PH_COMMAND && fi >= {1'b0, clen}) begin
      ph = PH_PAYLOAD;
      fi = 3'd0;
    end
    if (ph == PH_PAYLOAD && left_next == '0) begin
      ph = PH_TRAILER;
      fi = 3'd0;
    end
    case (ph)
      PH_HEADER: begin
        crc_next = crc_byte(crc_base, in_byte);
        phase_next = PH_HEADER;
        idx_next = fi + 3'd1;
      end
      PH_LENGTH: begin
        crc_next = crc_byte(crc_base, in_byte);
        if (big_endian) len_full = {len_base[23:0], in_byte};
        else len_full = len_base | ({24'd0, in_byte} << {fi[1:0], 3'b000});
        length_next = len_full;
        if ((fi + 3'd1) < llen) begin
          phase_next = PH_LENGTH;
          idx_next = fi + 3'd1;
        end else begin
          payload = {1'b0, len_full} - {31'd0, clen} - 33'd4;
          if (len_full < ({30'd0, clen} + 32'd4) || payload > MaxPay) begin
            res_valid = 1'b1;
            res.kind = 1'b1;
            res.length_error = 1'b1;
            phase_next = PH_HEADER;
            idx_next = 3'd0;
          end else begin
            length_next = payload[31:0];
            left_next = payload[LeftW-1:0];
            phase_next = PH_COMMAND;
            idx_next = 3'd0;
          end
        end
      end
      PH_COMMAND: begin
        crc_next = crc_byte(crc_base, in_byte);
        if (big_endian) command_next = {command_next[7:0], in_byte};
        else command_next = command_next | ({8'd0, in_byte} << {fi[0], 3'b000});
        phase_next = PH_COMMAND;
        idx_next = fi + 3'd1;
      end
      PH_PAYLOAD: begin
        crc_next = crc_byte(crc_base, in_byte);
        left_next = left_next - LeftW'(1);
        res_valid = 1'b1;
        res.out_byte = in_byte;
        phase_next = PH_PAYLOAD;
        idx_next = 3'd0;
      end
      PH_TRAILER: begin
        if (big_endian) trail_full = {trailer_next[23:0], in_byte};
        else trail_full = trailer_next | ({24'd0, in_byte} << {fi[1:0], 3'b000});
        trailer_next = trail_full;
        if ((fi + 3'd1) < 3'd4) begin
          phase_next = PH_TRAILER;
          idx_next = fi + 3'd1;
        end else begin
          res_valid = 1'b1;
          res.kind = 1'b1;
          res.command_value = command_next;
          res.payload_count = length_next[16:0];
          res.crc_ok = ((crc_base ^ ALL_ONES) == trail_full);
          phase_next = PH_HEADER;
          idx_next = 3'd0;
        end
      end
      default: begin
        phase_next = PH_HEADER;
        idx_next = 3'd0;
      end
    endcase
    if (!fire) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      idx <= 3'd0;
      crc_running <= ALL_ONES;
      length_accum <= '0;
      command_accum <= '0;
      bytes_left <= '0;
      trailer_accum <= '0;
    end else if (fire) begin
      phase <= phase_next;
      idx <= idx_next;
      crc_running <= crc_next;
      length_accum <= length_next;
      command_accum <= command_next;
      bytes_left <= left_next;
      trailer_accum <= trailer_next;
    end
  end

endmodule

/* rtl/core/fpc_queue.sv */
// ----------------------------------------------------------------------------
// fpc_queue
// Back end: a two-entry queue of result requests that drives the output
// channel, so the parser keeps taking bytes while a result waits.
// ----------------------------------------------------------------------------
`include "frame_parser_crc32_check_core_assert.svh"
module fpc_queue import fpc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  result_t wdata,
  input  logic    rd,
  output logic    full,
  output logic    nonempty,
  output result_t rdata
);

  result_t     mem [2];
  logic        wp, rp;
  logic [1:0]  count;

  assign full = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  `FPC_ASSERT_IMP(a_no_overflow, clk, rst, full, !wr, "queue written while full")
  `FPC_ASSERT_IMP(a_no_underflow, clk, rst, !nonempty, !rd, "queue read while empty")
  `FPC_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= 2'd2, "queue count out of range")

endmodule

/* rtl/core/frame_parser_crc32_check_core.sv */
// ----------------------------------------------------------------------------
// frame_parser_crc32_check_core
// Length-prefixed frame parser with CRC-32 check.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock with no bubbles while the output
// keeps up: the parser processes each byte with one table-free CRC-32 byte
// update plus field assembly, and its result, if any, reaches the output
// queue in the same cycle. A two-entry queue sits in front of the output
// channel; input stalls only when that queue is full.
`include "frame_parser_crc32_check_core_assert.svh"
module frame_parser_crc32_check_core import fpc_pkg::*; #(
  parameter int MAX_PAYLOAD = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  out_byte,
  output logic [15:0] command_value,
  output logic [16:0] payload_count,
  output logic        crc_ok,
  output logic        length_error
);

  logic        big_endian;
  logic [2:0]  header_len, length_field_len;
  logic [1:0]  command_field_len;
  logic [31:0] crc_seed;
  logic        fire, res_valid, q_full, q_rd;
  result_t     res, q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b1;
      header_len <= 3'd2;
      length_field_len <= 3'd2;
      command_field_len <= 2'd2;
      crc_seed <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIG_ENDIAN:  big_endian <= cfg_data[0];
        REG_HEADER_LEN:  header_len <= cfg_data[2:0];
        REG_LENGTH_LEN:  length_field_len <= cfg_data[2:0];
        REG_COMMAND_LEN: command_field_len <= cfg_data[1:0];
        REG_CRC_SEED:    crc_seed <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign fire = in_valid && !q_full;
  assign q_rd = out_valid && !out_stall;

  fpc_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
    .clk(clk), .rst(rst), .fire(fire), .in_byte(in_byte),
    .big_endian(big_endian), .header_len(header_len),
    .length_field_len(length_field_len), .command_field_len(command_field_len),
    .crc_seed(crc_seed), .res_valid(res_valid), .res(res)
  );

  fpc_queue u_queue (
    .clk(clk), .rst(rst), .wr(res_valid), .wdata(res), .rd(q_rd),
    .full(q_full), .nonempty(out_valid), .rdata(q_data)
  );

  assign kind = q_data.kind;
  assign out_byte = q_data.out_byte;
  assign command_value = q_data.command_value;
  assign payload_count = q_data.payload_count;
  assign crc_ok = q_data.crc_ok;
  assign length_error = q_data.length_error;

  `FPC_ASSERT_IMP(a_result_needs_byte, clk, rst, res_valid, fire, "result without byte")
  `FPC_ASSERT_IMP(a_lerr_is_status, clk, rst, out_valid && length_error, kind && !crc_ok,
                  "length error on non-status")
  `FPC_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && out_stall, out_valid,
                   "output dropped while stalled")

endmodule
